/* rtl/sdrrip_pkg.sv */
// Shared types and constants for the DRRIP/stream replacement unit.
// No dependencies.
package sdrrip_pkg;

  typedef struct packed {
    logic        operation;
    logic [10:0] set_index;
    logic [3:0]  way_index;
    logic [63:0] phys_address;
    logic [63:0] pc_value;
    logic        was_hit;
    logic        victim_valid;
    logic [4:0]  brrip_draw;
  } req_t;

  typedef struct packed {
    logic [3:0] victim_way;
    logic       set_streaming;
  } rsp_t;

  localparam logic [1:0] AGE_MAX = 2'd3;
  localparam logic [1:0] CTR_MAX = 2'd3;
  localparam logic       OP_VICTIM = 1'b0;
  localparam logic       OP_UPDATE = 1'b1;
  localparam logic [0:0] REG_LEADER = 1'd0;
  localparam logic [0:0] REG_THRESH = 1'd1;
  localparam logic [10:0] LEADER_RESET = 11'd32;
  localparam logic [1:0]  THRESH_RESET = 2'd3;

endpackage

/* rtl/ship_drrip_stream_replacement.sv */
// Top level of the DRRIP replacement unit with per-set stream detection.
// Depends on sdrrip_pkg.
//
// channel | signals                         | direction
// req     | req_valid, req_stall, req       | in (unit drives req_stall)
// rsp     | rsp_valid, rsp_stall, rsp       | out (sink drives rsp_stall)
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A request steps through read, modify and write states; the result register
// loads in the write state and the result is held in the output state until
// rsp_stall is low.  A new request is not accepted until the last result has
// been taken.  After reset a clearing pass sweeps every set and counter row
// before the first request is taken.
// A result held by rsp_stall blocks the next request; the result register
// is the only output stage.
module ship_drrip_stream_replacement #(
  parameter int NUM_SETS       = 2048,
  parameter int NUM_WAYS       = 16,
  parameter int TABLE_ENTRIES  = 16384,
  parameter int HISTORY_DEPTH  = 4,
  parameter int SELECTOR_WIDTH = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  sdrrip_pkg::req_t   req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output sdrrip_pkg::rsp_t   rsp,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [0:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int SW  = $clog2(NUM_SETS);
  localparam int WW  = $clog2(NUM_WAYS);
  localparam int TW  = $clog2(TABLE_ENTRIES);
  localparam int HW  = $clog2(HISTORY_DEPTH);
  localparam int TRW = TW - 2;          // table row: 4 counters per row
  localparam int TROWS = TABLE_ENTRIES / 4;
  localparam int CLRN = (NUM_SETS > TROWS) ? NUM_SETS : TROWS;
  localparam int CW  = $clog2(CLRN + 1);
  localparam int KW  = ((SW > 11) ? SW : 11) + 1;   // leader range compare
  localparam int SETW = 2*NUM_WAYS + 64 + 64*HISTORY_DEPTH + HW + 1;
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MID = {1'b1, {(SELECTOR_WIDTH-1){1'b0}}};
  localparam logic [SELECTOR_WIDTH-1:0] SEL_MAX = '1;

  // per-set record: ages, previous address, history, pointer, mark
  typedef struct packed {
    logic [NUM_WAYS-1:0][1:0]       ages;
    logic [63:0]                    prev;
    logic [HISTORY_DEPTH-1:0][63:0] hist;
    logic [HW-1:0]                  ptr;
    logic                           mark;
  } set_rec_t;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_CALC, S_WRITE, S_OUT} state_t;

  set_rec_t set_mem [NUM_SETS];
  logic [3:0][1:0] ctr_mem [TROWS];

  state_t state;
  logic [CW-1:0] clr_cnt;
  sdrrip_pkg::req_t cur;
  set_rec_t rd_set, wr_set;
  logic [3:0][1:0] rd_ctr, wr_ctr;
  logic [SELECTOR_WIDTH-1:0] sel;
  logic [10:0] leader_cnt;
  logic [1:0]  thresh;
  logic [WW-1:0] victim;

  logic [SW-1:0] set_a;
  logic [WW-1:0] way_a;
  logic [TW-1:0] tidx;
  logic [63:0]   pc_h;

  assign set_a = SW'(cur.set_index);
  assign way_a = WW'(cur.way_index);
  assign pc_h  = (cur.pc_value >> 2) ^ (cur.pc_value >> 11);
  assign tidx  = pc_h[TW-1:0];

  assign req_stall = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // memory ports
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_set <= set_mem[set_a];
      rd_ctr <= ctr_mem[tidx[TW-1:2]];
    end
    if (state == S_CLEAR) begin
      if (clr_cnt < CW'(NUM_SETS)) begin
        set_mem[clr_cnt[SW-1:0]] <= '{ages: {NUM_WAYS{sdrrip_pkg::AGE_MAX}},
                                      prev: '0, hist: '0, ptr: '0, mark: 1'b0};
      end
      if (clr_cnt < CW'(TROWS)) ctr_mem[clr_cnt[TRW-1:0]] <= {4{2'd1}};
    end else if (state == S_WRITE) begin
      set_mem[set_a] <= wr_set;
      ctr_mem[tidx[TW-1:2]] <= wr_ctr;
    end
  end

  // modify step
  logic [1:0] top, add, fill, ctr, ctr_n, kind;
  logic [63:0] delta;
  logic [HISTORY_DEPTH-1:0][63:0] h;
  logic [3:0] match;
  logic new_mark;
  logic [SELECTOR_WIDTH-1:0] sel_n;
  logic [WW-1:0] vic_n;
  set_rec_t ns;
  logic [3:0][1:0] nc;
  logic [2:0] a3;
  logic found;
  logic [KW-1:0] lc_ext, sum_ext;

  always_comb begin
    ns = rd_set;
    nc = rd_ctr;
    sel_n = sel;
    vic_n = '0;
    top = '0;
    add = '0;
    fill = sdrrip_pkg::AGE_MAX;
    delta = '0;
    h = rd_set.hist;
    match = '0;
    new_mark = rd_set.mark;
    kind = 2'd0;
    ctr = rd_ctr[tidx[1:0]];
    ctr_n = ctr;
    found = 1'b0;
    a3 = '0;
    lc_ext = KW'(leader_cnt);
    sum_ext = KW'(set_a) + lc_ext;
    if (cur.operation == sdrrip_pkg::OP_VICTIM) begin
      // age the set, then find the first way at max age
      for (int w = 0; w < NUM_WAYS; w++) if (rd_set.ages[w] > top) top = rd_set.ages[w];
      if (top < sdrrip_pkg::AGE_MAX) begin
        add = rd_set.mark ? 2'd1 : (sdrrip_pkg::AGE_MAX - top);
        for (int w = 0; w < NUM_WAYS; w++) begin
          a3 = {1'b0, rd_set.ages[w]} + {1'b0, add};
          ns.ages[w] = (a3 > 3'd3) ? sdrrip_pkg::AGE_MAX : a3[1:0];
        end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (!found && ns.ages[w] == sdrrip_pkg::AGE_MAX) begin
          found = 1'b1;
          vic_n = WW'(w);
        end
      end
    end else begin
      // record delta and refresh streaming mark
      if (rd_set.prev != '0) delta = cur.phys_address - rd_set.prev;
      ns.prev = cur.phys_address;
      h[rd_set.ptr] = delta;
      ns.hist = h;
      ns.ptr = (rd_set.ptr == HW'(HISTORY_DEPTH - 1)) ? '0 : rd_set.ptr + 1'b1;
      for (int i = 1; i < HISTORY_DEPTH; i++)
        if (h[0] != '0 && h[i] == h[0]) match = match + 4'd1;
      new_mark = (match >= {2'b0, thresh});
      ns.mark = new_mark;
      if (lc_ext > KW'(set_a)) kind = 2'd1;
      else if (sum_ext >= KW'(NUM_SETS)) kind = 2'd2;
      if (cur.was_hit) begin
        ns.ages[way_a] = 2'd0;
        if (ctr < sdrrip_pkg::CTR_MAX) ctr_n = ctr + 2'd1;
      end else if (new_mark) begin
        ns.ages[way_a] = sdrrip_pkg::AGE_MAX;
      end else begin
        if (ctr <= 2'd1) fill = sdrrip_pkg::AGE_MAX;
        else if (ctr == 2'd2) begin
          if (kind == 2'd1 || (kind == 2'd0 && sel >= SEL_MID)) fill = 2'd2;
          else fill = (cur.brrip_draw == 5'd0) ? 2'd2 : sdrrip_pkg::AGE_MAX;
        end else fill = 2'd0;
        ns.ages[way_a] = fill;
        if (cur.victim_valid && fill == sdrrip_pkg::AGE_MAX && ctr != 2'd0)
          ctr_n = ctr - 2'd1;
        if (kind == 2'd1 && sel != SEL_MAX) sel_n = sel + 1'b1;
        else if (kind == 2'd2 && sel != '0) sel_n = sel - 1'b1;
      end
      nc[tidx[1:0]] = ctr_n;
    end
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      sel <= SEL_MID;
      leader_cnt <= sdrrip_pkg::LEADER_RESET;
      thresh <= sdrrip_pkg::THRESH_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          sdrrip_pkg::REG_LEADER: leader_cnt <= cfg_data;
          sdrrip_pkg::REG_THRESH: thresh <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(CLRN - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            cur <= req;
            state <= S_READ;
          end
        end
        S_READ: state <= S_CALC;
        S_CALC: begin
          wr_set <= ns;
          wr_ctr <= nc;
          sel <= sel_n;
          victim <= vic_n;
          state <= S_WRITE;
        end
        S_WRITE: begin
          rsp.victim_way <= 4'(victim);
          rsp.set_streaming <= wr_set.mark;
          rsp_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_stall) begin
            rsp_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for ship_drrip_stream_replacement: RRIP victim choice,
// reuse-counter training, set dueling and stride stream detection.
// Depends on sdrrip_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int SETS = 2048;
  localparam int WAYS = 16;
  localparam int CTRS = 16384;
  localparam int HIST = 4;
  localparam int SEL_TOP = 1023;
  localparam int SEL_HALF = 512;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  sdrrip_pkg::req_t  req = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  sdrrip_pkg::rsp_t  rsp;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index = sdrrip_pkg::REG_LEADER;
  logic [10:0]       cfg_data = '0;

  // Predictor copy of the replacement state
  logic [1:0]  age_q [SETS*WAYS];
  logic [1:0]  reuse_q [CTRS];
  logic [63:0] last_addr_q [SETS];
  logic [63:0] delta_q [SETS][HIST];
  logic [1:0]  hptr_q [SETS];
  logic        stream_q [SETS];
  int          selector;
  logic [10:0] leaders;
  logic [1:0]  threshold;

  sdrrip_pkg::rsp_t pending_decisions [$];
  int   errors = 0;
  int   idle_pct = 0;
  int   stall_pct = 0;

  ship_drrip_stream_replacement dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  initial begin
    for (int i = 0; i < SETS*WAYS; i++) age_q[i] = sdrrip_pkg::AGE_MAX;
    for (int i = 0; i < CTRS; i++) reuse_q[i] = 2'd1;
    for (int s = 0; s < SETS; s++) begin
      last_addr_q[s] = '0;
      hptr_q[s] = '0;
      stream_q[s] = 1'b0;
      for (int h = 0; h < HIST; h++) delta_q[s][h] = '0;
    end
    selector = SEL_HALF;
    leaders = sdrrip_pkg::LEADER_RESET;
    threshold = sdrrip_pkg::THRESH_RESET;
  end

  // 1 = SRRIP leader, 2 = BRRIP leader, 0 = follower
  function automatic int duel_role(int s);
    if (s < leaders) return 1;
    if (s + leaders >= SETS) return 2;
    return 0;
  endfunction

  function automatic sdrrip_pkg::rsp_t compute_decision(sdrrip_pkg::req_t r);
    sdrrip_pkg::rsp_t o;
    int          s, w, base, top, add, hits, idx, role, cnt, fill;
    logic [63:0] delta;
    s = int'(r.set_index);
    w = int'(r.way_index);
    base = s * WAYS;
    o = '0;
    if (r.operation == sdrrip_pkg::OP_VICTIM) begin
      top = 0;
      for (int i = 0; i < WAYS; i++) if (age_q[base+i] > top) top = age_q[base+i];
      if (top < sdrrip_pkg::AGE_MAX) begin
        add = stream_q[s] ? 1 : sdrrip_pkg::AGE_MAX - top;
        for (int i = 0; i < WAYS; i++)
          age_q[base+i] = 2'((age_q[base+i] + add > sdrrip_pkg::AGE_MAX) ?
                             sdrrip_pkg::AGE_MAX : age_q[base+i] + add);
      end
      for (int i = WAYS - 1; i >= 0; i--)
        if (age_q[base+i] == sdrrip_pkg::AGE_MAX) o.victim_way = 4'(i);
    end else begin
      idx = int'(((r.pc_value >> 2) ^ (r.pc_value >> 11)) & 64'(CTRS - 1));
      // record the stride and refresh the streaming mark
      delta = (last_addr_q[s] != 0) ? r.phys_address - last_addr_q[s] : 64'd0;
      last_addr_q[s] = r.phys_address;
      delta_q[s][hptr_q[s]] = delta;
      hptr_q[s] = hptr_q[s] + 2'd1;
      hits = 0;
      for (int i = 1; i < HIST; i++)
        if (delta_q[s][0] != 0 && delta_q[s][i] == delta_q[s][0]) hits++;
      stream_q[s] = (hits >= threshold);
      if (r.was_hit) begin
        age_q[base+w] = 2'd0;
        if (reuse_q[idx] < sdrrip_pkg::CTR_MAX) reuse_q[idx] = reuse_q[idx] + 2'd1;
      end else if (stream_q[s]) begin
        age_q[base+w] = sdrrip_pkg::AGE_MAX;
      end else begin
        role = duel_role(s);
        cnt = int'(reuse_q[idx]);
        if (cnt <= 1) fill = sdrrip_pkg::AGE_MAX;
        else if (cnt == 2) begin
          if (role == 1 || (role == 0 && selector >= SEL_HALF))
            fill = sdrrip_pkg::AGE_MAX - 1;
          else fill = (r.brrip_draw == 0) ? sdrrip_pkg::AGE_MAX - 1 : sdrrip_pkg::AGE_MAX;
        end else fill = 0;
        age_q[base+w] = 2'(fill);
        if (r.victim_valid && fill == sdrrip_pkg::AGE_MAX && reuse_q[idx] > 0)
          reuse_q[idx] = reuse_q[idx] - 2'd1;
        if (role == 1 && selector < SEL_TOP) selector++;
        else if (role == 2 && selector > 0) selector--;
      end
    end
    o.set_streaming = stream_q[s];
    return o;
  endfunction

  // Receiver stall pattern
  always @(posedge clk) rsp_stall <= ($urandom_range(99) < stall_pct);

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    sdrrip_pkg::rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_decisions.size() == 0) begin
        $display("%0t: unexpected result way %0d stream %0b", $time,
                 rsp.victim_way, rsp.set_streaming);
        errors++;
      end else begin
        want = pending_decisions.pop_front();
        if (rsp.victim_way !== want.victim_way) begin
          $display("%0t: victim_way expected %0d got %0d", $time,
                   want.victim_way, rsp.victim_way);
          errors++;
        end
        if (rsp.set_streaming !== want.set_streaming) begin
          $display("%0t: set_streaming expected %0b got %0b", $time,
                   want.set_streaming, rsp.set_streaming);
          errors++;
        end
      end
    end
  end

  // Present one request, predict at acceptance; valid stays high for a follower
  task automatic send_req(input sdrrip_pkg::req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    pending_decisions.push_back(compute_decision(r));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    wait (pending_decisions.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == sdrrip_pkg::REG_LEADER) leaders = val;
    else threshold = val[1:0];
  endtask

  function automatic sdrrip_pkg::req_t make_req(logic op, int s, int w, logic [63:0] a,
                                                logic [63:0] pc, logic hit, logic ev,
                                                int d);
    sdrrip_pkg::req_t r;
    r.operation = op;
    r.set_index = 11'(s);
    r.way_index = 4'(w);
    r.phys_address = a;
    r.pc_value = pc;
    r.was_hit = hit;
    r.victim_valid = ev;
    r.brrip_draw = 5'(d);
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random request biased toward strided streams in a few sets and a small pc pool
  function automatic sdrrip_pkg::req_t random_req();
    int          s, pick;
    logic [63:0] a, pc, stride;
    pick = $urandom_range(9);
    case (pick)
      0, 1: s = $urandom_range(3);
      2, 3: s = SETS - 1 - $urandom_range(3);
      4, 5: s = 1000 + $urandom_range(3);
      6: s = $urandom_range(SETS - 1);
      default: s = 30 + $urandom_range(4);
    endcase
    case ($urandom_range(5))
      0: stride = 64'd64;
      1: stride = -64'd128;
      2: stride = 64'd4096;
      default: stride = 64'd0;
    endcase
    if (stride == 0 || $urandom_range(9) == 0) a = rand64();
    else a = last_addr_q[s] + stride;
    pc = ($urandom_range(7) == 0) ? rand64() : 64'h4000 + 64'($urandom_range(7) << 2);
    return make_req($urandom_range(99) < 40 ? sdrrip_pkg::OP_VICTIM : sdrrip_pkg::OP_UPDATE,
                    s, $urandom_range(15), a, pc, 1'($urandom_range(1)),
                    1'($urandom_range(1)),
                    $urandom_range(3) == 0 ? 0 : $urandom_range(31));
  endfunction

  task automatic run_random(input int n, input int sidle, input int rstall);
    idle_pct = sidle;
    stall_pct = rstall;
    repeat (n) send_req(random_req());
    idle_pct = 0;
    stall_pct = 0;
  endtask

  // Corner items: set and way extremes, counter paths, dueling roles, a stream
  task automatic test_directed();
    logic [63:0] pa;
    pa = 64'h4000;
    send_req(make_req(sdrrip_pkg::OP_VICTIM, 0, 0, '0, '0, 0, 0, 0));
    send_req(make_req(sdrrip_pkg::OP_VICTIM, SETS - 1, 15, '1, '1, 1, 1, 31));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, SETS - 1, 15, '1, '1, 0, 1, 31));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 0, 0, 64'h1, '0, 0, 1, 0));
    // train one counter up to saturation, then fill with it
    repeat (3) send_req(make_req(sdrrip_pkg::OP_UPDATE, 700, 3, 64'h9000, pa, 1, 0, 5));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 700, 4, 64'h9040, pa, 0, 1, 5));
    send_req(make_req(sdrrip_pkg::OP_VICTIM, 700, 0, '0, pa, 0, 0, 0));
    // counter two: follower, SRRIP leader, BRRIP leader with draw zero and not
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 800, 1, 64'hA000, 64'h8000, 1, 0, 0));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 800, 2, 64'hB000, 64'h8000, 0, 1, 7));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 1, 2, 64'hB000, 64'h8000, 0, 1, 7));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, SETS - 2, 2, 64'hB000, 64'h8000, 0, 1, 0));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, SETS - 2, 3, 64'hC000, 64'h8000, 0, 1, 9));
    // evicting fill at counter one decrements it
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 900, 5, 64'hD000, 64'hC00, 0, 1, 3));
    send_req(make_req(sdrrip_pkg::OP_VICTIM, 900, 0, '0, '0, 0, 0, 0));
    // constant stride marks the set streaming
    for (int i = 0; i < 6; i++)
      send_req(make_req(sdrrip_pkg::OP_UPDATE, 5, i, 64'h10000 + 64 * i, 64'h500, 0, 0, 1));
    send_req(make_req(sdrrip_pkg::OP_VICTIM, 5, 0, '0, '0, 0, 0, 0));
    send_req(make_req(sdrrip_pkg::OP_VICTIM, 5, 0, '0, '0, 0, 0, 0));
    send_req(make_req(sdrrip_pkg::OP_UPDATE, 5, 9, 64'h10180, 64'h500, 1, 0, 1));
    drain();
  endtask

  // Thresholds one, zero and two against random strided traffic, then back to three
  task automatic test_thresholds();
    write_reg(sdrrip_pkg::REG_THRESH, 11'd1);
    run_random(250, 58, 0);
    drain();
    write_reg(sdrrip_pkg::REG_THRESH, 11'd0);
    run_random(200, 0, 58);
    drain();
    write_reg(sdrrip_pkg::REG_THRESH, 11'd2);
    run_random(250, 13, 13);
    drain();
    write_reg(sdrrip_pkg::REG_THRESH, 11'd3);
  endtask

  // Leader counts at both ends and between
  task automatic test_leaders();
    write_reg(sdrrip_pkg::REG_LEADER, 11'd0);
    run_random(250, 0, 0);
    drain();
    write_reg(sdrrip_pkg::REG_LEADER, 11'd1024);
    run_random(200, 58, 0);
    drain();
    write_reg(sdrrip_pkg::REG_LEADER, 11'd1023);
    write_reg(sdrrip_pkg::REG_THRESH, 11'd1);
    run_random(200, 0, 58);
    drain();
    write_reg(sdrrip_pkg::REG_LEADER, 11'd5);
    run_random(200, 13, 13);
  endtask

  // Sender holds off until every result is back, then resumes
  task automatic test_drain_pause();
    run_random(40, 0, 58);
    req_valid <= 1'b0;
    wait (pending_decisions.size() == 0);
    run_random(80, 0, 0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_thresholds();
    test_leaders();
    test_drain_pause();
    req_valid <= 1'b0;
    wait (pending_decisions.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("ship_drrip_stream_replacement test passed");
    else $display("ship_drrip_stream_replacement test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("ship_drrip_stream_replacement test failed");
    $finish;
  end

endmodule
